// ----- rtl/sepwm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted-edge multichannel PWM: shared definitions
// Channel count, derived widths, command codes and the item record that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package sepwm_pkg;

	// Channel count and the widths that follow from it.
	localparam int CHANNELS = 6;
	localparam int SLOTS    = CHANNELS + 1;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int NIDX_W   = $clog2(SLOTS + 1);
	localparam int ADDR_W   = $clog2(2 * SLOTS);
	localparam int CNT_W    = $clog2(CHANNELS + 1);

	// Fixed field widths.
	localparam int FUNC_W = 2;
	localparam int CHAN_W = 3;
	localparam int DUTY_W = 8;
	localparam int TIME_W = 8;

	// Command queue depth.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Register map and reset values.
	localparam logic [1:0]        REG_MIN_GAP   = 2'd0;
	localparam logic [TIME_W-1:0] MIN_GAP_RESET = 8'd16;
	localparam logic [TIME_W-1:0] TIME_MAX      = 8'hff;

	// Function codes on the input port.
	localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_COMMIT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_EVENT  = 2'd2;

	// Classified command kinds.
	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_COMMIT,
		CMD_EVENT,
		CMD_REJECT
	} cmd_kind_t;

	// One queued item.
	typedef struct packed {
		cmd_kind_t         kind;
		logic [CH_W-1:0]   channel;
		logic [DUTY_W-1:0] duty;
	} cmd_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SORT,
		ST_BUILD,
		ST_FIN_TAIL,
		ST_FIN_END,
		ST_EV_NEXT
	} back_state_t;

endpackage
`default_nettype wire

// ----- rtl/sepwm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted-edge multichannel PWM: front end
// Accepts items from the command port and classifies them into writes,
// commits, compare events and rejected requests before queueing.
// ----------------------------------------------------------------------------
module sepwm_front import sepwm_pkg::*; (
	input  wire logic              start,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [CHAN_W-1:0] channel,
	input  wire logic [DUTY_W-1:0] duty,
	input  wire logic              q_full,
	output logic                   busy,
	output logic                   push,
	output cmd_t                   push_item
);

	logic chan_ok;

	// The port stalls only when the queue has no room.
	assign busy = q_full;
	assign push = start && !q_full;

	// Classify the request; out-of-range writes and unknown codes are rejected.
	always_comb begin
		chan_ok = (32'(channel) < 32'(CHANNELS));
		push_item.channel = channel[CH_W-1:0];
		push_item.duty    = duty;
		case (func)
			FUNC_WRITE: begin
				push_item.kind = chan_ok ? CMD_WRITE : CMD_REJECT;
			end
			FUNC_COMMIT: begin
				push_item.kind = CMD_COMMIT;
			end
			FUNC_EVENT: begin
				push_item.kind = CMD_EVENT;
			end
			default: begin
				push_item.kind = CMD_REJECT;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/sepwm_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted-edge multichannel PWM: command queue
// Short first-in first-out buffer that decouples the front end from the
// back end so either side can stall on its own.
// ----------------------------------------------------------------------------
module sepwm_queue import sepwm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_item,
	input  wire logic pop,
	output logic      full,
	output logic      empty,
	output cmd_t      head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sepwm_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted-edge multichannel PWM: back end
// Executes queued items in order: duty writes, schedule commits (load,
// odd-even sort, edge build into the idle half) and compare-event playback.
// ----------------------------------------------------------------------------
module sepwm_back import sepwm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [TIME_W-1:0]   min_gap,
	input  wire logic                q_empty,
	input  wire cmd_t                head,
	output logic                     pop,
	output logic                     done,
	output logic [CHANNELS-1:0]      pin_levels,
	output logic [TIME_W-1:0]        compare_value,
	output logic                     period_start,
	output logic                     accepted
);

	back_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	// Architectural state.
	logic [DUTY_W-1:0]   duty_q  [CHANNELS];
	logic [TIME_W-1:0]   iv_q    [2*SLOTS];
	logic [CHANNELS-1:0] mk_q    [2*SLOTS];
	logic [CH_W-1:0]     order_q [CHANNELS];
	logic                half_q;
	logic                pend_q;
	logic [IDX_W-1:0]    step_q;
	logic [CHANNELS-1:0] pin_q;

	// Commit work registers.
	logic [DUTY_W-1:0]   wk_key_q [CHANNELS];
	logic [CH_W-1:0]     wk_ch_q  [CHANNELS];
	logic [DUTY_W-1:0]   srt_key  [CHANNELS];
	logic [CH_W-1:0]     srt_ch   [CHANNELS];
	logic [TIME_W-1:0]   now_q;
	logic [CNT_W-1:0]    e_q;
	logic [CHANNELS-1:0] rise_q;
	logic [CHANNELS-1:0] cur_q;

	// Event second-step registers.
	logic [NIDX_W-1:0] ev_nidx_q;
	logic [ADDR_W-1:0] ev_addr_q;

	// Result registers.
	logic                done_q;
	logic [CHANNELS-1:0] pins_out_q;
	logic [TIME_W-1:0]   cmp_q;
	logic                period_q;
	logic                acc_q;

	// Dispatch and event signals.
	logic                go;
	logic                commit_go;
	logic                event_go;
	logic [IDX_W-1:0]    idx0;
	logic                is_first;
	logic                ev_half;
	logic [ADDR_W-1:0]   ev_addr;
	logic [NIDX_W-1:0]   ev_nidx;
	logic [CHANNELS-1:0] ev_pins;
	logic [ADDR_W-1:0]   rd_addr;
	logic [TIME_W-1:0]   iv_rd;
	logic [CHANNELS-1:0] mk_rd;

	// Build signals.
	logic [ADDR_W-1:0]   build_base;
	logic [ADDR_W-1:0]   b_addr_e;
	logic [ADDR_W-1:0]   b_addr_e1;
	logic [DUTY_W-1:0]   b_key;
	logic [CH_W-1:0]     b_ch;
	logic [CHANNELS-1:0] b_bit;
	logic                b_on;
	logic signed [8:0]   b_diff;
	logic signed [8:0]   half_gap;
	logic                b_merge;
	logic [TIME_W-1:0]   b_int;

	// Store write ports.
	logic                iv_we;
	logic [ADDR_W-1:0]   iv_wa;
	logic [TIME_W-1:0]   iv_wd;
	logic                mk_we;
	logic [ADDR_W-1:0]   mk_wa;
	logic [CHANNELS-1:0] mk_wd;

	// Dispatch of the queue head, only from idle.
	assign go        = (state_q == ST_IDLE) && !q_empty;
	assign pop       = go;
	assign commit_go = go && (head.kind == CMD_COMMIT) && !pend_q;
	assign event_go  = go && (head.kind == CMD_EVENT);

	// Compare-event step: pick the half, the slot and the new pin levels.
	always_comb begin
		idx0     = (32'(step_q) >= 32'(SLOTS)) ? '0 : step_q;
		is_first = (idx0 == '0);
		ev_half  = (is_first && pend_q) ? ~half_q : half_q;
		ev_addr  = ev_half ? ADDR_W'(SLOTS) + ADDR_W'(idx0) : ADDR_W'(idx0);
		ev_nidx  = NIDX_W'(idx0) + 1'b1;
		rd_addr  = (state_q == ST_EV_NEXT) ? ev_addr_q : ev_addr;
		iv_rd    = iv_q[rd_addr];
		mk_rd    = mk_q[ev_addr];
		if (is_first) begin
			ev_pins = ((pend_q) ? '0 : pin_q) | mk_rd;
		end else begin
			ev_pins = pin_q & ~mk_rd;
		end
	end

	// One build step on the channel at the head of the sorted list.
	always_comb begin
		build_base = half_q ? '0 : ADDR_W'(SLOTS);
		b_addr_e   = build_base + ADDR_W'(e_q);
		b_addr_e1  = b_addr_e + 1'b1;
		b_key      = wk_key_q[0];
		b_ch       = wk_ch_q[0];
		b_bit      = CHANNELS'(1) << b_ch;
		b_on       = (b_key > min_gap);
		b_diff     = $signed({1'b0, b_key}) - $signed({1'b0, now_q});
		half_gap   = $signed({2'b00, min_gap[TIME_W-1:1]});
		b_merge    = (b_diff < half_gap);
		b_int      = (b_diff[7:0] < min_gap) ? min_gap : b_diff[7:0];
	end

	// One odd-even transposition pass; strict compare keeps the sort stable.
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			srt_key[i] = wk_key_q[i];
			srt_ch[i]  = wk_ch_q[i];
		end
		for (int i = 0; i + 1 < CHANNELS; i++) begin
			if (((i % 2) == 1) == cnt_q[0] && wk_key_q[i] > wk_key_q[i+1]) begin
				srt_key[i]   = wk_key_q[i+1];
				srt_ch[i]    = wk_ch_q[i+1];
				srt_key[i+1] = wk_key_q[i];
				srt_ch[i+1]  = wk_ch_q[i];
			end
		end
	end

	// Schedule store write ports.
	always_comb begin
		iv_we = 1'b0;
		iv_wa = b_addr_e;
		iv_wd = b_int;
		mk_we = 1'b0;
		mk_wa = b_addr_e1;
		mk_wd = b_bit;
		case (state_q)
			ST_BUILD: begin
				if (b_on && !b_merge) begin
					iv_we = 1'b1;
					mk_we = 1'b1;
				end else if (b_on && e_q != '0) begin
					mk_we = 1'b1;
					mk_wa = b_addr_e;
					mk_wd = cur_q | b_bit;
				end
			end
			ST_FIN_TAIL: begin
				iv_we = 1'b1;
				iv_wd = TIME_MAX - now_q;
				mk_we = 1'b1;
				mk_wa = build_base;
				mk_wd = rise_q;
			end
			ST_FIN_END: begin
				iv_we = (32'(e_q) < 32'(SLOTS - 1));
				iv_wa = b_addr_e1;
				iv_wd = '0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (commit_go) begin
					state_d = ST_LOAD;
				end else if (event_go) begin
					state_d = ST_EV_NEXT;
				end
			end
			ST_LOAD: begin
				if (cnt_q == CNT_W'(CHANNELS - 1)) begin
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				if (cnt_q == CNT_W'(CHANNELS - 1)) begin
					state_d = ST_BUILD;
				end
			end
			ST_BUILD: begin
				if (cnt_q == CNT_W'(CHANNELS - 1)) begin
					state_d = ST_FIN_TAIL;
				end
			end
			ST_FIN_TAIL: begin
				state_d = ST_FIN_END;
			end
			ST_FIN_END: begin
				state_d = ST_IDLE;
			end
			ST_EV_NEXT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Schedule stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2 * SLOTS; i++) begin
				iv_q[i] <= '0;
				mk_q[i] <= '0;
			end
		end else begin
			if (iv_we) begin
				iv_q[iv_wa] <= iv_wd;
			end
			if (mk_we) begin
				mk_q[mk_wa] <= mk_wd;
			end
		end
	end

	// Duty store, sort order and playback state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				duty_q[i]  <= '0;
				order_q[i] <= CH_W'(i);
			end
			half_q <= 1'b0;
			pend_q <= 1'b0;
			step_q <= '0;
			pin_q  <= '0;
		end else begin
			if (go && head.kind == CMD_WRITE) begin
				duty_q[head.channel] <= head.duty;
			end
			if (commit_go) begin
				pend_q <= 1'b1;
			end
			if (event_go) begin
				half_q <= ev_half;
				pin_q  <= ev_pins;
				if (is_first) begin
					pend_q <= 1'b0;
				end
			end
			if (state_q == ST_EV_NEXT) begin
				if (32'(ev_nidx_q) >= 32'(SLOTS) || iv_rd == '0) begin
					step_q <= '0;
				end else begin
					step_q <= ev_nidx_q[IDX_W-1:0];
				end
			end
			if (state_q == ST_BUILD && cnt_q == '0) begin
				for (int i = 0; i < CHANNELS; i++) begin
					order_q[i] <= wk_ch_q[i];
				end
			end
		end
	end

	// Commit work registers: load keys, sort, then walk in sorted order.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (commit_go) begin
					for (int i = 0; i < CHANNELS; i++) begin
						wk_ch_q[i] <= order_q[i];
					end
				end
				now_q  <= '0;
				e_q    <= '0;
				rise_q <= '0;
				cur_q  <= '0;
			end
			ST_LOAD: begin
				for (int i = 0; i + 1 < CHANNELS; i++) begin
					wk_key_q[i] <= wk_key_q[i+1];
					wk_ch_q[i]  <= wk_ch_q[i+1];
				end
				wk_key_q[CHANNELS-1] <= duty_q[wk_ch_q[0]];
				wk_ch_q[CHANNELS-1]  <= wk_ch_q[0];
			end
			ST_SORT: begin
				for (int i = 0; i < CHANNELS; i++) begin
					wk_key_q[i] <= srt_key[i];
					wk_ch_q[i]  <= srt_ch[i];
				end
			end
			ST_BUILD: begin
				for (int i = 0; i + 1 < CHANNELS; i++) begin
					wk_key_q[i] <= wk_key_q[i+1];
					wk_ch_q[i]  <= wk_ch_q[i+1];
				end
				wk_key_q[CHANNELS-1] <= wk_key_q[0];
				wk_ch_q[CHANNELS-1]  <= wk_ch_q[0];
				if (b_on) begin
					rise_q <= rise_q | b_bit;
					if (!b_merge) begin
						cur_q <= b_bit;
						now_q <= now_q + b_int;
						e_q   <= e_q + 1'b1;
					end else if (e_q != '0) begin
						cur_q <= cur_q | b_bit;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Event second step bookkeeping.
	always_ff @(posedge clk) begin
		if (event_go) begin
			ev_nidx_q <= ev_nidx;
			ev_addr_q <= (32'(ev_nidx) < 32'(SLOTS)) ? ev_addr + 1'b1 : '0;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= go;
		end
	end

	// Result payload, captured when an item is dispatched.
	always_ff @(posedge clk) begin
		if (go) begin
			pins_out_q <= event_go ? ev_pins : pin_q;
			cmp_q      <= event_go ? iv_rd : '0;
			period_q   <= event_go && is_first;
			case (head.kind)
				CMD_WRITE: begin
					acc_q <= 1'b1;
				end
				CMD_COMMIT: begin
					acc_q <= !pend_q;
				end
				CMD_EVENT: begin
					acc_q <= 1'b1;
				end
				default: begin
					acc_q <= 1'b0;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign pin_levels    = pins_out_q;
	assign compare_value = cmp_q;
	assign period_start  = period_q;
	assign accepted      = acc_q;

endmodule
`default_nettype wire

// ----- rtl/sorted_edge_multichannel_pwm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted-edge multichannel PWM sequencer
// Duty writes, schedule commits and compare events enter through a command
// port, wait in a two-entry queue and are executed in order by the back end.
// An item waits in the queue until the back end is idle; done is registered
// from its dispatch. Writes and rejected items finish in idle, a compare
// event takes a second read state, and a commit runs load (single duty
// read), CHANNELS sort passes, one build step per channel and two closing
// writes; busy is high while the queue is full. Reset is asynchronous:
// stores clear at once, pin image low (pin_levels unreset), min_gap = 16.
// ----------------------------------------------------------------------------
module sorted_edge_multichannel_pwm import sepwm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Command port
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [CHAN_W-1:0]   channel,
	input  wire logic [DUTY_W-1:0]   duty,
	// Result port
	output logic                     done,
	output logic [CHANNELS-1:0]      pin_levels,
	output logic [TIME_W-1:0]        compare_value,
	output logic                     period_start,
	output logic                     accepted,
	// Configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [1:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic [TIME_W-1:0] min_gap_q;
	logic              q_full;
	logic              q_empty;
	logic              push;
	logic              pop;
	cmd_t              push_item;
	cmd_t              head;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_MIN_GAP) ? 32'(min_gap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= MIN_GAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_MIN_GAP) begin
			min_gap_q <= pwdata[TIME_W-1:0];
		end
	end

	// Front end: accept and classify.
	sepwm_front u_front (
		.start     (start),
		.func      (func),
		.channel   (channel),
		.duty      (duty),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.push_item (push_item)
	);

	// Queue between front and back.
	sepwm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	// Back end: execute items in order.
	sepwm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.min_gap       (min_gap_q),
		.q_empty       (q_empty),
		.head          (head),
		.pop           (pop),
		.done          (done),
		.pin_levels    (pin_levels),
		.compare_value (compare_value),
		.period_start  (period_start),
		.accepted      (accepted)
	);

endmodule
`default_nettype wire

// ----- bench/pwm_sequencer_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted-edge PWM sequencer checker
// Watches the command port, the result port and the configuration port.
// Every accepted item is run through a cycle-free model of the duty store,
// the channel sort, the schedule builder and the playback sequencer, and
// the result it predicts is queued. Each done strobe is compared field by
// field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module pwm_sequencer_checker import sepwm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [CHAN_W-1:0]   channel,
	input  wire logic [DUTY_W-1:0]   duty,
	input  wire logic                done,
	input  wire logic [CHANNELS-1:0] pin_levels,
	input  wire logic [TIME_W-1:0]   compare_value,
	input  wire logic                period_start,
	input  wire logic                accepted,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [1:0]          paddr,
	input  wire logic [31:0]         pwdata,
	input  wire logic                pready,
	output int                       mismatches,
	output int                       outstanding
);

	localparam logic [1:0] GAP_ADDR = 2'(4 * REG_MIN_GAP);

	typedef struct packed {
		logic [CHANNELS-1:0] pins;
		logic [TIME_W-1:0]   cmp;
		logic                period;
		logic                acc;
	} pwm_result_t;

	// Model state: duty store, two schedule halves and the playback pointer.
	logic [DUTY_W-1:0]   duty_mem [CHANNELS];
	logic [TIME_W-1:0]   intv_mem [2*SLOTS];
	logic [CHANNELS-1:0] mask_mem [2*SLOTS];
	int                  order [CHANNELS];
	logic                live_half;
	logic                swap_wait;
	int                  step_pos;
	logic [CHANNELS-1:0] pin_img;
	logic [TIME_W-1:0]   gap;

	pwm_result_t expected_results[$];
	pwm_result_t want;
	pwm_result_t got;

	task automatic clear_model();
		for (int i = 0; i < CHANNELS; i++) begin
			duty_mem[i] = '0;
			order[i] = i;
		end
		for (int i = 0; i < 2*SLOTS; i++) begin
			intv_mem[i] = '0;
			mask_mem[i] = '0;
		end
		live_half = 1'b0;
		swap_wait = 1'b0;
		step_pos = 0;
		pin_img = '0;
		gap = MIN_GAP_RESET;
	endtask

	// Stable bubble sort of the channel order by duty; the order persists.
	task automatic sort_by_duty();
		int t;
		for (int n = CHANNELS; n > 1; n--) begin
			for (int i = 0; i + 1 < n; i++) begin
				if (duty_mem[order[i]] > duty_mem[order[i+1]]) begin
					t = order[i];
					order[i] = order[i+1];
					order[i+1] = t;
				end
			end
		end
	endtask

	// Build one schedule half: a rising mask in slot 0, then one falling
	// group per slot. Close edges are merged, short intervals stretched.
	task automatic build_table(input int base);
		int now_t;
		int e;
		int nxt;
		int half_gap;
		int ch;
		logic [CHANNELS-1:0] bitm;
		now_t = 0;
		e = 0;
		half_gap = int'(gap) / 2;
		mask_mem[base] = '0;
		for (int p = 0; p < CHANNELS; p++) begin
			ch = order[p] % CHANNELS;
			if (duty_mem[ch] > gap) begin
				bitm = CHANNELS'(1) << ch;
				nxt = int'(duty_mem[ch]) - now_t;
				mask_mem[base] |= bitm;
				if (nxt < half_gap) begin
					mask_mem[base+e] |= bitm;
				end else begin
					if (nxt < int'(gap))
						nxt = int'(gap);
					mask_mem[base+e+1] = bitm;
					intv_mem[base+e] = TIME_W'(nxt);
					now_t = (now_t + nxt) & int'(TIME_MAX);
					e++;
				end
			end
		end
		intv_mem[base+e] = TIME_W'(int'(TIME_MAX) - now_t);
		if (e < SLOTS - 1)
			intv_mem[base+e+1] = '0;
	endtask

	// Predict the result of one item and advance the model.
	task automatic play_command(input logic [FUNC_W-1:0] f, input logic [CHAN_W-1:0] c,
			input logic [DUTY_W-1:0] d, output pwm_result_t r);
		int idx;
		int base;
		r = '0;
		case (f)
			FUNC_WRITE: begin
				if (c < CHANNELS) begin
					duty_mem[c] = d;
					r.acc = 1'b1;
				end
			end
			FUNC_COMMIT: begin
				if (!swap_wait) begin
					sort_by_duty();
					build_table(live_half ? 0 : SLOTS);
					swap_wait = 1'b1;
					r.acc = 1'b1;
				end
			end
			FUNC_EVENT: begin
				idx = step_pos;
				if (idx >= SLOTS)
					idx = 0;
				if (idx == 0) begin
					// Period start: a pending schedule takes over, pins clear first.
					r.period = 1'b1;
					if (swap_wait) begin
						live_half = ~live_half;
						swap_wait = 1'b0;
						pin_img = '0;
					end
					base = live_half ? SLOTS : 0;
					pin_img |= mask_mem[base];
				end else begin
					base = live_half ? SLOTS : 0;
					pin_img &= ~mask_mem[base+idx];
				end
				r.cmp = intv_mem[base+idx];
				idx++;
				if (idx >= SLOTS)
					idx = 0;
				else if (intv_mem[base+idx] == '0)
					idx = 0;
				step_pos = idx;
				r.acc = 1'b1;
			end
			default: ;
		endcase
		r.pins = pin_img;
	endtask

	initial begin
		mismatches = 0;
		clear_model();
	end

	// Results are retired before new items are predicted in the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			expected_results.delete();
		end else begin
			if (done) begin
				got = '{pins: pin_levels, cmp: compare_value, period: period_start,
					acc: accepted};
				if (expected_results.size() == 0) begin
					$error("result with no item waiting: pins %0h cmp %0h", pin_levels,
						compare_value);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got.pins !== want.pins) begin
						$error("pin_levels: expected %0h, got %0h", want.pins, got.pins);
						mismatches++;
					end
					if (got.cmp !== want.cmp) begin
						$error("compare_value: expected %0d, got %0d", want.cmp, got.cmp);
						mismatches++;
					end
					if (got.period !== want.period) begin
						$error("period_start: expected %0b, got %0b", want.period,
							got.period);
						mismatches++;
					end
					if (got.acc !== want.acc) begin
						$error("accepted: expected %0b, got %0b", want.acc, got.acc);
						mismatches++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == GAP_ADDR)
				gap = pwdata[TIME_W-1:0];
			if (start && !busy) begin
				play_command(func, channel, duty, want);
				expected_results.push_back(want);
			end
		end
		outstanding = expected_results.size();
	end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Sorted-edge PWM sequencer testbench
// Drives duty writes, commits and compare events into the sequencer, first
// a directed run under the reset gap, then phases of write-commit-play
// sequences mixed with malformed items, each phase under its own minimum
// gap and one of three sender idle rates. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import sepwm_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam logic [1:0]        GAP_ADDR   = 2'(4 * REG_MIN_GAP);

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [FUNC_W-1:0]   func = '0;
	logic [CHAN_W-1:0]   channel = '0;
	logic [DUTY_W-1:0]   duty = '0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [1:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic                busy;
	logic                done;
	logic [CHANNELS-1:0] pin_levels;
	logic [TIME_W-1:0]   compare_value;
	logic                period_start;
	logic                accepted;
	logic [31:0]         prdata;
	logic                pready;
	int                  mismatches;
	int                  outstanding;

	int                  idle_pct = 0;
	logic [TIME_W-1:0]   cur_gap = MIN_GAP_RESET;

	sorted_edge_multichannel_pwm dut (.*);

	pwm_sequencer_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Present one item and hold it until the block takes it.
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CHAN_W-1:0] c,
			input logic [DUTY_W-1:0] d);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		channel <= c;
		duty <= d;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Let every outstanding result come back with start held low.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_gap(input logic [TIME_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= GAP_ADDR;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_gap = v;
	endtask

	// Duties cluster around the gap threshold so merging and stretching occur.
	function automatic logic [DUTY_W-1:0] rand_duty();
		case ($urandom_range(6))
			0: return '0;
			1: return '1;
			2: return cur_gap;
			3: return DUTY_W'(cur_gap + 1);
			4: return DUTY_W'(cur_gap - 1);
			5: return DUTY_W'(cur_gap + $urandom_range(cur_gap));
			default: return DUTY_W'($urandom);
		endcase
	endfunction

	// Mostly whole write-commit-play sequences, some stray items between.
	task automatic random_traffic(input int target);
		int sent;
		int n;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(99) < 75) begin
				n = $urandom_range(6, 1);
				for (int k = 0; k < n; k++)
					send_item(FUNC_WRITE, CHAN_W'($urandom_range(CHANNELS-1)), rand_duty());
				send_item(FUNC_COMMIT, CHAN_W'($urandom), DUTY_W'($urandom));
				sent += n + 1;
				n = $urandom_range(16, 3);
				for (int k = 0; k < n; k++)
					send_item(FUNC_EVENT, CHAN_W'($urandom), DUTY_W'($urandom));
				sent += n;
			end else begin
				case ($urandom_range(4))
					0: send_item(FUNC_WRITE, CHAN_W'($urandom_range(7, CHANNELS)),
						DUTY_W'($urandom));
					1: send_item(FUNC_SPARE, CHAN_W'($urandom), DUTY_W'($urandom));
					2: begin
						send_item(FUNC_COMMIT, CHAN_W'($urandom), DUTY_W'($urandom));
						sent++;
					end
					3: begin
						send_item(FUNC_EVENT, CHAN_W'($urandom), DUTY_W'($urandom));
						sent++;
					end
					default: begin
						send_item(FUNC_WRITE, CHAN_W'($urandom_range(CHANNELS-1)),
							rand_duty());
						sent++;
					end
				endcase
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed run under the reset gap: empty schedule, stray items,
		// threshold and merge duties, refused commit, swap and playback.
		send_item(FUNC_EVENT, '0, '0);
		send_item(FUNC_EVENT, '1, '1);
		send_item(FUNC_WRITE, 3'd6, 8'haa);
		send_item(FUNC_WRITE, 3'd7, 8'h55);
		send_item(FUNC_SPARE, 3'd2, 8'h11);
		send_item(FUNC_WRITE, 3'd0, 8'hff);
		send_item(FUNC_WRITE, 3'd1, 8'h00);
		send_item(FUNC_WRITE, 3'd2, 8'd17);
		send_item(FUNC_WRITE, 3'd3, 8'd16);
		send_item(FUNC_WRITE, 3'd4, 8'd20);
		send_item(FUNC_WRITE, 3'd5, 8'd100);
		send_item(FUNC_COMMIT, '0, '0);
		send_item(FUNC_COMMIT, '0, '0);
		for (int k = 0; k < 8; k++)
			send_item(FUNC_EVENT, '0, '0);
		send_item(FUNC_WRITE, 3'd5, 8'h00);
		send_item(FUNC_COMMIT, '0, '0);
		for (int k = 0; k < 4; k++)
			send_item(FUNC_EVENT, '0, '0);
		drain();

		// Random phases, each under its own gap and one of three idle rates.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_gap('0);
				1: write_gap('1);
				2: write_gap(TIME_W'($urandom_range(40, 8)));
				3: write_gap(TIME_W'(1));
				4: write_gap(TIME_W'($urandom));
				default: write_gap(MIN_GAP_RESET);
			endcase
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 48;
				default: idle_pct = 12;
			endcase
			random_traffic(180);
			drain();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
